### hw/rtl/deadline_event_queue_unit_assert.svh
// assertion macros for the deadline event queue unit
// used by modules that check their own sequencing; no other dependencies
`ifndef DEADLINE_EVENT_QUEUE_UNIT_ASSERT_SVH
`define DEADLINE_EVENT_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition in one cycle implies a condition in the next
`define DEQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hw/rtl/deq_pkg.sv
// shared types and constants of the deadline event queue
// no dependencies
`timescale 1ns / 1ps

package deq_pkg;

  localparam int TimeW      = 48;
  localparam int MaxAddrW   = 6;
  localparam int DefDepth   = 16;
  localparam int DefOwners  = 8;
  localparam int MaxFired   = 16;
  localparam int FiredW     = 5;
  localparam int MultW      = 36;
  localparam logic [19:0] UsecPerS  = 20'd1000000;
  localparam logic [15:0] WarnLeadS = 16'd10;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_POLL     = 2'd1,
    OP_PURGE    = 2'd2,
    OP_PURGE_WR = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_FIRED    = 3'd0,
    KIND_WAIT     = 3'd1,
    KIND_INSERTED = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_PURGED   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    TYPE_TICK  = 2'd0,
    TYPE_WARN  = 2'd1,
    TYPE_WRITE = 2'd2,
    TYPE_SLEEP = 2'd3
  } evtype_e;

  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [2:0]       owner;
    logic [1:0]       etype;
    logic [15:0]      payload;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic [MaxAddrW-1:0] waddr;
    entry_t              wdata;
    logic [MaxAddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0]  mask;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    opcode_e          op;
    logic [TimeW-1:0] event_time;
    logic [TimeW-1:0] now_time;
    logic [TimeW-1:0] max_wait;
    logic [2:0]       owner;
    logic [1:0]       etype;
    logic [15:0]      payload;
    logic             purge_sleep;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [2:0]       owner;
    logic [1:0]       etype;
    logic [15:0]      payload;
    logic [TimeW-1:0] wait_time;
    logic [4:0]       removed;
    logic             last;
  } res_t;

endpackage

### hw/rtl/deq_mem.sv
// entry store of the queue: one write port, one registered read port
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_mem import deq_pkg::*; #(
  parameter int Depth = DefDepth
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  localparam int IdxW = $clog2(Depth);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  // write then registered read, old data on same-address collision
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[IdxW-1:0]] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr[IdxW-1:0]];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/deq_seq.sv
// sequencer: sorted insert, head pop with tick re-arm, purge compaction
// depends on deq_pkg and deq_mem, assertions from the macro header
`timescale 1ns / 1ps
`include "deadline_event_queue_unit_assert.svh"

module deq_seq import deq_pkg::*; #(
  parameter int Depth      = DefDepth,
  parameter int OwnerCount = DefOwners
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_o
);

  localparam int CntW = $clog2(Depth + 1);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_INS_START = 11'b00000000010,
    S_INS_CMP   = 11'b00000000100,
    S_INS_PUT   = 11'b00000001000,
    S_POLL_HEAD = 11'b00000010000,
    S_POLL_CHK  = 11'b00000100000,
    S_POP_ST    = 11'b00001000000,
    S_POP_SH    = 11'b00010000000,
    S_REARM_MUL = 11'b00100000000,
    S_REARM_ADD = 11'b01000000000,
    S_PUR_CHK   = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    SRC_EXT  = 2'd0,
    SRC_WARN = 2'd1,
    SRC_TICK = 2'd2
  } src_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic   emit_q, emit_d;
  src_e   src_q, src_d;
  logic [CntW-1:0]   cnt_q, cnt_d, idx_q, idx_d, wr_q, wr_d, rem_q, rem_d;
  logic [FiredW-1:0] fired_q, fired_d;
  item_t  item_q, item_d;
  entry_t new_q, new_d, hd_q, hd_d;
  logic [MultW-1:0]  mult_q, mult_d;
  res_t   res_q, res_d, mres_q, mres_d;
  logic   m_valid_q, m_valid_d;

  mem_req_t req;
  entry_t   rdata;
  logic     ins_end, ins_ok, pop_end, do_tick, hit, due;
  logic [CntW-1:0]  rem_nx;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] diff;

  deq_mem #(.Depth(Depth)) u_mem (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  // re-arm condition of the popped head and purge match of the entry read
  assign do_tick = (hd_q.etype == TYPE_TICK) && (32'(hd_q.owner) < OwnerCount)
                   && cfg_i.mask[hd_q.owner];
  assign hit = (rdata.owner == item_q.owner) &&
               ((item_q.op == OP_PURGE) || (rdata.etype == TYPE_WRITE) ||
                (item_q.purge_sleep && (rdata.etype == TYPE_SLEEP)));
  assign rem_nx = rem_q + CntW'(hit);
  assign due  = rdata.deadline <= item_q.now_time;
  assign diff = rdata.deadline - item_q.now_time;
  assign sum  = {1'b0, item_q.now_time} + (TimeW + 1)'(mult_q);

  // main sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  emit_d = 1'b0;  src_d = src_q;
    cnt_d = cnt_q;  idx_d = idx_q;  wr_d = wr_q;  rem_d = rem_q;
    fired_d = fired_q;  item_d = item_q;  new_d = new_q;  hd_d = hd_q;
    mult_d = mult_q;  res_d = res_q;  mres_d = mres_q;
    m_valid_d = m_valid_q & ~out_ready_i;
    req = '0;
    ins_end = 1'b0;  ins_ok = 1'b0;  pop_end = 1'b0;
    in_ready_o = 1'b0;

    // pending result goes to the output register when it frees up
    if (emit_q) begin
      if (!m_valid_q || out_ready_i) begin
        m_valid_d = 1'b1;
        mres_d    = res_q;
        state_d   = ret_q;
      end else begin
        emit_d = 1'b1;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            item_d  = in_i;
            fired_d = '0;
            src_d   = SRC_EXT;
            new_d   = '{deadline: in_i.event_time, owner: in_i.owner,
                        etype: in_i.etype, payload: in_i.payload};
            unique case (in_i.op)
              OP_INSERT: state_d = S_INS_START;
              OP_POLL:   state_d = S_POLL_HEAD;
              OP_PURGE, OP_PURGE_WR: begin
                if (cnt_q == '0) begin
                  res_d = '0;  res_d.kind = KIND_PURGED;  res_d.last = 1'b1;
                  emit_d = 1'b1;  ret_d = S_IDLE;
                end else begin
                  req.raddr = '0;  idx_d = '0;  wr_d = '0;  rem_d = '0;
                  state_d = S_PUR_CHK;
                end
              end
              default: state_d = S_IDLE;
            endcase
          end
        end
        // insert: walk down from the tail, shifting later entries up
        S_INS_START: begin
          if (cnt_q == CntW'(Depth)) begin
            ins_end = 1'b1;
          end else if (cnt_q == '0) begin
            req.we = 1'b1;  req.waddr = '0;  req.wdata = new_q;
            cnt_d = cnt_q + 1'b1;  ins_end = 1'b1;  ins_ok = 1'b1;
          end else begin
            idx_d = cnt_q;
            req.raddr = MaxAddrW'(cnt_q - 1'b1);
            state_d = S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          req.we = 1'b1;
          if (rdata.deadline > new_q.deadline) begin
            req.waddr = MaxAddrW'(idx_q);  req.wdata = rdata;
            idx_d = idx_q - 1'b1;
            if (idx_q == CntW'(1)) begin
              state_d = S_INS_PUT;
            end else begin
              req.raddr = MaxAddrW'(idx_q - CntW'(2));
            end
          end else begin
            req.waddr = MaxAddrW'(idx_q);  req.wdata = new_q;
            cnt_d = cnt_q + 1'b1;  ins_end = 1'b1;  ins_ok = 1'b1;
          end
        end
        S_INS_PUT: begin
          req.we = 1'b1;  req.waddr = MaxAddrW'(idx_q);  req.wdata = new_q;
          cnt_d = cnt_q + 1'b1;  ins_end = 1'b1;  ins_ok = 1'b1;
        end
        // poll: look at the head
        S_POLL_HEAD: begin
          if (cnt_q == '0) begin
            res_d = '0;  res_d.kind = KIND_WAIT;
            res_d.wait_time = item_q.max_wait;  res_d.last = 1'b1;
            emit_d = 1'b1;  ret_d = S_IDLE;
          end else begin
            req.raddr = '0;
            state_d = S_POLL_CHK;
          end
        end
        S_POLL_CHK: begin
          res_d = '0;
          if (due && (fired_q != FiredW'(MaxFired))) begin
            hd_d = rdata;
            res_d.kind = KIND_FIRED;  res_d.owner = rdata.owner;
            res_d.etype = rdata.etype;  res_d.payload = rdata.payload;
            fired_d = fired_q + 1'b1;
            cnt_d = cnt_q - 1'b1;
            ret_d = S_POP_ST;
          end else begin
            res_d.kind = KIND_WAIT;  res_d.last = 1'b1;
            if (due) begin
              res_d.wait_time = '0;
            end else begin
              res_d.wait_time = (diff < item_q.max_wait) ? diff : item_q.max_wait;
            end
            ret_d = S_IDLE;
          end
          emit_d = 1'b1;
        end
        // pop: move remaining entries down one slot
        S_POP_ST: begin
          if (cnt_q == '0) begin
            pop_end = 1'b1;
          end else begin
            req.raddr = MaxAddrW'(1);  idx_d = CntW'(1);
            state_d = S_POP_SH;
          end
        end
        S_POP_SH: begin
          req.we = 1'b1;  req.waddr = MaxAddrW'(idx_q - 1'b1);  req.wdata = rdata;
          if (idx_q < cnt_q) begin
            idx_d = idx_q + 1'b1;
            req.raddr = MaxAddrW'(idx_q + 1'b1);
          end else begin
            pop_end = 1'b1;
          end
        end
        // re-arm deadline: period (less the warning lead for a warning) times one million, then saturating add
        S_REARM_MUL: begin
          mult_d = MultW'((src_q == SRC_WARN) ? (cfg_i.period - WarnLeadS) : cfg_i.period)
                   * MultW'(UsecPerS);
          state_d = S_REARM_ADD;
        end
        S_REARM_ADD: begin
          new_d.deadline = sum[TimeW] ? '1 : sum[TimeW-1:0];
          new_d.owner    = hd_q.owner;
          new_d.etype    = (src_q == SRC_WARN) ? TYPE_WARN : TYPE_TICK;
          new_d.payload  = '0;
          state_d = S_INS_START;
        end
        // purge: compact survivors toward the head
        S_PUR_CHK: begin
          if (!hit) begin
            req.we = 1'b1;  req.waddr = MaxAddrW'(wr_q);  req.wdata = rdata;
          end
          wr_d  = wr_q + CntW'(!hit);
          rem_d = rem_nx;
          if (idx_q + 1'b1 < cnt_q) begin
            idx_d = idx_q + 1'b1;
            req.raddr = MaxAddrW'(idx_q + 1'b1);
          end else begin
            cnt_d = wr_q + CntW'(!hit);
            res_d = '0;  res_d.kind = KIND_PURGED;  res_d.last = 1'b1;
            res_d.removed = (32'(rem_nx) > 31) ? 5'd31 : 5'(rem_nx);
            emit_d = 1'b1;  ret_d = S_IDLE;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end

    // end of an insert: report, or continue the re-arm chain
    if (ins_end) begin
      case (src_q)
        SRC_EXT: begin
          res_d = '0;  res_d.kind = ins_ok ? KIND_INSERTED : KIND_FULL;
          res_d.last = 1'b1;
          emit_d = 1'b1;  ret_d = S_IDLE;
        end
        SRC_WARN: begin
          src_d = SRC_TICK;  state_d = S_REARM_MUL;
        end
        default: state_d = S_POLL_HEAD;
      endcase
    end

    // end of a pop: re-arm a ticking owner's tick, and first its warning if the period exceeds the warning lead
    if (pop_end) begin
      if (do_tick) begin
        src_d = (cfg_i.period > WarnLeadS) ? SRC_WARN : SRC_TICK;
        state_d = S_REARM_MUL;
      end else begin
        state_d = S_POLL_HEAD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      emit_q    <= 1'b0;
      src_q     <= SRC_EXT;
      cnt_q     <= '0;
      idx_q     <= '0;
      wr_q      <= '0;
      rem_q     <= '0;
      fired_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      emit_q    <= emit_d;
      src_q     <= src_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      wr_q      <= wr_d;
      rem_q     <= rem_d;
      fired_q   <= fired_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    new_q  <= new_d;
    hd_q   <= hd_d;
    mult_q <= mult_d;
    res_q  <= res_d;
    mres_q <= mres_d;
  end

  assign out_valid_o = m_valid_q;
  assign out_o       = mres_q;

  `DEQ_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "entry count beyond depth")
  `DEQ_ASSERT(a_wr_range, req.we |-> (MaxAddrW'(cnt_q) >= req.waddr), "write past fill")
  `DEQ_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o, state_q != S_IDLE || emit_q, "item lost")

endmodule

### hw/rtl/deadline_event_queue_unit.sv
// Deadline event queue: a time-ordered queue of 48-bit microsecond deadlines
// held in one single-port-write, registered-read memory and walked by a
// sequencer, one entry per cycle. One item at a time is taken. An insert
// shifts each entry after the new one up a slot, then writes it; a purge
// reads every queued entry once; a poll reads the head and, for each
// fired entry, shifts the rest down a slot and, for a ticking owner,
// re-arms by a multiply, an add and an insert. A stalled output holds it.
// There is no clearing pass after reset. Depends on deq_pkg, deq_seq, deq_mem.
`timescale 1ns / 1ps

module deadline_event_queue_unit import deq_pkg::*; #(
  parameter int QueueDepth = DefDepth,
  parameter int OwnerCount = DefOwners
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  // input beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // event_time, now_time, max_wait, owner, event_type, payload, purge_sleep
  input  logic [167:0] s_axis_tdata,
  // opcode
  input  logic [1:0]   s_axis_tuser,
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // owner_out, type_out, payload_out, wait_time, removed_count
  output logic [79:0]  m_axis_tdata,
  // kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  cfg_t  cfg_q;
  item_t item;
  res_t  res;

  // config registers, always accepted
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask   <= 8'd0;
      cfg_q.period <= 16'd60;
    end else if (cfg_valid_i) begin
      if (cfg_index_i) begin
        cfg_q.period <= cfg_data_i;
      end else begin
        cfg_q.mask <= cfg_data_i[7:0];
      end
    end
  end

  // unpack input beat
  always_comb begin
    item.op          = opcode_e'(s_axis_tuser);
    item.event_time  = s_axis_tdata[47:0];
    item.now_time    = s_axis_tdata[95:48];
    item.max_wait    = s_axis_tdata[143:96];
    item.owner       = s_axis_tdata[146:144];
    item.etype       = s_axis_tdata[148:147];
    item.payload     = s_axis_tdata[164:149];
    item.purge_sleep = s_axis_tdata[165];
  end

  deq_seq #(.Depth(QueueDepth), .OwnerCount(OwnerCount)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_i       (item),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  // pack result beat
  assign m_axis_tdata = {6'd0, res.removed, res.wait_time, res.payload, res.etype, res.owner};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
